[sv/aem_pkg.sv]
// aem_pkg: shared types and constants for the audio echo mixer.
// Used by every module of the block but aem_ram; depends on nothing.
package aem_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned DELAY_W       = 15;
  localparam int unsigned DIVISOR_W     = 16;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam int unsigned MAX_DELAY_DEF = 16384;
  localparam int unsigned RESET_DELAY   = 8000;
  localparam int unsigned RESET_DIVISOR = 4;
  localparam int unsigned DIVISOR_CAP   = 32768;

  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned DIV_STEPS     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_DELAY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_DIVISOR = 1'b1;

  // input action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  // one beat from front to back: current sample and raw delayed sample
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [SAMPLE_W-1:0] echo;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

[sv/aem_ram.sv]
// aem_ram: generic simple dual-port RAM, one write and one registered read.
// Read-first on a same-address collision. No dependencies.
module aem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/aem_front.sv]
// aem_front: accepts input beats, drives the delay line RAM and tracks fill.
// Depends on aem_pkg; instantiates aem_ram for the delay line.
module aem_front #(
  parameter int unsigned MAX_DELAY = aem_pkg::MAX_DELAY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_action,
  input  logic signed [aem_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [aem_pkg::DELAY_W-1:0]         echo_delay,
  input  logic                                q_full,
  output logic                                q_push,
  output aem_pkg::entry_t                     q_entry
);

  localparam int unsigned AW = $clog2(MAX_DELAY);
  localparam int unsigned CW = (AW + 1 > aem_pkg::DELAY_W) ? AW + 1 : aem_pkg::DELAY_W;
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_DELAY);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_DELAY - 1);

  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          pend_r, pend_nxt;
  logic          pend_ok_r, pend_ok_nxt;
  logic signed [aem_pkg::SAMPLE_W-1:0] pend_cur_r, pend_cur_nxt;

  logic                             accept;
  logic [CW-1:0]                    dly;
  logic [CW-1:0]                    wp_ext;
  logic [CW-1:0]                    rd_ext;
  logic [AW-1:0]                    rd_addr;
  logic signed [aem_pkg::SAMPLE_W-1:0] cur;
  logic [aem_pkg::SAMPLE_W-1:0]     rd_data;

  assign in_full = pend_r | q_full;
  assign accept  = in_push & ~in_full;
  assign cur     = (in_action == aem_pkg::ACT_DRAIN) ? '0 : in_sample;

  always_comb begin
    dly = CW'(echo_delay);
    if (dly == '0) begin
      dly = CW'(1);
    end
    if (dly > MAX_C) begin
      dly = MAX_C;
    end
    wp_ext = CW'(wp_r);
    if (wp_ext >= dly) begin
      rd_ext = wp_ext - dly;
    end else begin
      rd_ext = wp_ext + MAX_C - dly;
    end
    rd_addr = rd_ext[AW-1:0];
  end

  aem_ram #(
    .WIDTH (aem_pkg::SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wp_r),
    .wr_data (cur),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    pend_nxt     = 1'b0;
    pend_ok_nxt  = pend_ok_r;
    pend_cur_nxt = pend_cur_r;
    if (accept) begin
      wp_nxt       = (wp_r == LAST_A) ? '0 : wp_r + AW'(1);
      fill_nxt     = (fill_r == MAX_C) ? fill_r : fill_r + CW'(1);
      pend_nxt     = 1'b1;
      // entry behind the read address was written only once fill reaches the delay
      pend_ok_nxt  = (fill_r >= dly);
      pend_cur_nxt = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
    pend_ok_r  <= pend_ok_nxt;
    pend_cur_r <= pend_cur_nxt;
  end

  assign q_push        = pend_r;
  assign q_entry.cur   = pend_cur_r;
  assign q_entry.echo  = pend_ok_r ? rd_data : '0;

endmodule

[sv/aem_fifo.sv]
// aem_fifo: short queue of entry_t beats between front and back.
// Depends on aem_pkg.
module aem_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aem_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output aem_pkg::entry_t pop_data,
  output logic            empty
);

  localparam int unsigned QAW = $clog2(aem_pkg::QDEPTH);

  aem_pkg::entry_t slots_r [aem_pkg::QDEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QAW:0]    count_r;

  logic do_push, do_pop;

  assign full    = (count_r == (QAW+1)'(aem_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/aem_back.sv]
// aem_back: scales the echo with a bit-serial divider and mixes the result.
// Depends on aem_pkg; holds the result in an output register.
module aem_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  aem_pkg::entry_t                      q_entry,
  output logic                                 q_pop,
  input  logic [aem_pkg::DIVISOR_W-1:0]        divisor,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [aem_pkg::SAMPLE_W-1:0]  out_mixed
);

  localparam int unsigned SW  = aem_pkg::SAMPLE_W;
  localparam int unsigned DW  = aem_pkg::DIVISOR_W;
  localparam int unsigned CNW = $clog2(aem_pkg::DIV_STEPS);

  aem_pkg::bk_state_t state_r, state_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [SW-1:0]  quo_r, quo_nxt;
  logic           neg_r, neg_nxt;
  logic [SW-1:0]  cur_r, cur_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [SW-1:0]  out_mixed_r, out_mixed_nxt;

  logic [DW:0]    shifted;
  logic [DW:0]    diff;
  logic           ge;
  logic [SW-1:0]  quo_signed;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted    = {rem_r, quo_r[SW-1]};
  assign diff       = shifted - {1'b0, divisor};
  assign ge         = (shifted >= {1'b0, divisor});
  assign quo_signed = neg_r ? (~quo_r + SW'(1)) : quo_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_mixed_nxt = out_mixed_r;
    q_pop         = 1'b0;

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      aem_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_entry.cur;
          neg_nxt   = q_entry.echo[SW-1];
          // magnitude; the most negative value maps to 0x8000 unsigned
          quo_nxt   = q_entry.echo[SW-1] ? (~q_entry.echo + SW'(1)) : q_entry.echo;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = aem_pkg::BK_DIV;
        end
      end
      aem_pkg::BK_DIV: begin
        rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
        quo_nxt = {quo_r[SW-2:0], ge};
        cnt_nxt = cnt_r + CNW'(1);
        if (cnt_r == CNW'(aem_pkg::DIV_STEPS - 1)) begin
          state_nxt = aem_pkg::BK_DONE;
        end
      end
      aem_pkg::BK_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_mixed_nxt = cur_r + quo_signed;
          state_nxt     = aem_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = aem_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aem_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    neg_r       <= neg_nxt;
    cur_r       <= cur_nxt;
    out_mixed_r <= out_mixed_nxt;
  end

  assign out_empty = ~out_valid_r;
  assign out_mixed = out_mixed_r;

endmodule

[sv/audio_echo_mixer.sv]
// audio_echo_mixer: feedforward comb echo on signed 16-bit PCM samples.
// Depends on aem_pkg; instantiates aem_front, aem_fifo and aem_back.
//
// Input channel: push a beat with in_push while in_full is low. in_action
// selects a new sample or a drain tick (taken as a zero sample) that plays
// out the echo tail. Result channel: one beat per input beat, in order;
// out_mixed is valid while out_empty is low and is taken with out_pop.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 writes
// echo_delay, 1 writes volume_divisor; write only while the block is idle.
//
// An input beat passes the front with its delay line RAM read, the queue
// pop, 16 divider steps and the output load. The bit-serial divider that
// scales the echo term sets the rate: the back pops no new beat before the
// last is loaded out. The front runs ahead by up to two queued beats.
// Reset: delay line reads as zero through a fill count, so no clearing pass
// is needed; registers return to delay 8000, divisor 4. When the receiver
// stalls, the output register holds, the divider finishes its next beat,
// the queue fills and in_full rises.
module audio_echo_mixer #(
  parameter int unsigned MAX_DELAY = aem_pkg::MAX_DELAY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_action,
  input  logic signed [aem_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [aem_pkg::SAMPLE_W-1:0] out_mixed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aem_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aem_pkg::DIVISOR_W-1:0]       cfg_data
);

  logic [aem_pkg::DELAY_W-1:0]   echo_delay_r;
  logic [aem_pkg::DIVISOR_W-1:0] volume_divisor_r;
  logic [aem_pkg::DIVISOR_W-1:0] div_sat;

  logic            q_push, q_full, q_pop, q_empty;
  aem_pkg::entry_t q_wr_entry, q_rd_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_delay_r     <= aem_pkg::DELAY_W'(aem_pkg::RESET_DELAY);
      volume_divisor_r <= aem_pkg::DIVISOR_W'(aem_pkg::RESET_DIVISOR);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        aem_pkg::REG_ECHO_DELAY:     echo_delay_r     <= cfg_data[aem_pkg::DELAY_W-1:0];
        aem_pkg::REG_VOLUME_DIVISOR: volume_divisor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    div_sat = volume_divisor_r;
    if (div_sat == '0) begin
      div_sat = aem_pkg::DIVISOR_W'(1);
    end
    if (div_sat > aem_pkg::DIVISOR_W'(aem_pkg::DIVISOR_CAP)) begin
      div_sat = aem_pkg::DIVISOR_W'(aem_pkg::DIVISOR_CAP);
    end
  end

  aem_front #(
    .MAX_DELAY (MAX_DELAY)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_action  (in_action),
    .in_sample  (in_sample),
    .echo_delay (echo_delay_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_wr_entry)
  );

  aem_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd_entry),
    .empty     (q_empty)
  );

  aem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (q_rd_entry),
    .q_pop     (q_pop),
    .divisor   (div_sat),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_mixed (out_mixed)
  );

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue push while full");

  // the back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("queue pop while empty");

  // an accepted beat holds the front for the RAM read cycle
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> (in_full && q_push))
    else $error("front did not hold for pending beat");

endmodule
